// File: rtl/core/pad_pkg.sv
package pad_pkg;

    // field widths
    localparam int PRES_W = 17;
    localparam int TEMP_W = 11;
    localparam int HUM_W  = 10;
    localparam int OUT_W  = 16;

    // tetens exponent divider: |t|*75*log2(10)*2^16 over 10*(t+2373)
    localparam int Y_NW = 35;
    localparam int Y_DW = 16;
    localparam int Y_QW = 22;
    localparam int YP_W = 22;

    // density in 2^-32 kg/m3
    localparam int RF_NW = 64;
    localparam int RF_DW = 32;
    localparam int RF_QW = 34;

    // density in 1e-4 kg/m3
    localparam int DN_NW = 39;
    localparam int DN_DW = 25;
    localparam int DN_QW = 16;

    // squared speed
    localparam int Q_NW = 64;
    localparam int Q_DW = 34;
    localparam int Q_QW = 32;

    // square root
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;

    localparam logic [23:0] K_EXP    = 24'd16327950;
    localparam logic [26:0] POLY_C3  = 27'd85298265;
    localparam logic [27:0] POLY_C2  = 28'd241048919;
    localparam logic [29:0] POLY_C1  = 30'd747394747;
    localparam logic [30:0] ONE_Q30  = 31'd1073741824;
    localparam logic [15:0] TETENS_A = 16'd40028;
    localparam logic [14:0] MD_MICRO = 15'd28964;
    localparam logic [13:0] MDV_MICRO = 14'd10948;
    localparam logic [13:0] R_MILLI  = 14'd8314;
    localparam logic [19:0] R_RF     = 20'd831400;
    localparam logic [14:0] DP_SCALE = 15'd20000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_NOPOS = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    // density and flags that ride along with the last divider and the square root
    typedef struct packed {
        logic [OUT_W-1:0] dens;
        logic             npos;
        logic             lt;
        logic             gt;
        logic             sat;
    } t_fin;

endpackage

// File: rtl/core/pad_div.sv
module pad_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int QUO_W = 32,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [SB_W-1:0]  o_sb
);

    // one quotient bit per stage, restoring
    logic             r_vld [QUO_W];
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_lo  [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [SB_W-1:0]  r_sb  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] lo_in;
        logic [QUO_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_head
            assign vld_in = i_valid;
            assign rem_in = DEN_W'(i_num >> QUO_W);
            assign lo_in  = i_num[QUO_W-1:0];
            assign quo_in = '0;
            assign den_in = i_den;
            assign sb_in  = i_sb;
        end else begin : g_body
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign lo_in  = r_lo[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign sb_in  = r_sb[k-1];
        end

        assign trial = {rem_in, lo_in[QUO_W-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
            r_lo[k]  <= {lo_in[QUO_W-2:0], 1'b0};
            r_quo[k] <= {quo_in[QUO_W-2:0], ge};
            r_den[k] <= den_in;
            r_sb[k]  <= sb_in;
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_rem   = r_rem[QUO_W-1];
    assign o_sb    = r_sb[QUO_W-1];

endmodule

// File: rtl/core/pad_sqrt.sv
module pad_sqrt
    import pad_pkg::*;
#(
    parameter int SB_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]   o_sb
);

    localparam int REM_W = ROOT_W + 2;

    // two radicand bits per stage
    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [RAD_W-1:0]  r_lo   [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SB_W-1:0]   r_sb   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [RAD_W-1:0]  lo_in;
        logic [ROOT_W-1:0] root_in;
        logic [SB_W-1:0]   sb_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_head
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign lo_in   = i_rad;
            assign root_in = '0;
            assign sb_in   = i_sb;
        end else begin : g_body
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign lo_in   = r_lo[k-1];
            assign root_in = r_root[k-1];
            assign sb_in   = r_sb[k-1];
        end

        assign cur   = {rem_in, lo_in[RAD_W-1:RAD_W-2]};
        assign trial = (REM_W+2)'({root_in, 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
            r_lo[k]   <= {lo_in[RAD_W-3:0], 2'b00};
            r_root[k] <= {root_in[ROOT_W-2:0], ge};
            r_sb[k]   <= sb_in;
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_sb    = r_sb[ROOT_W-1];

endmodule

// File: rtl/core/pitot_airspeed_humid_density.sv
// pipeline: an accepted word reaches its o_done strobe through the registered stages, the four
//   bit-per-stage dividers (22, 34, 16, 32 stages) and the 16-stage square root
// throughput: one word per cycle, busy is low whenever reset is released
// results are strobed for one cycle on o_done; the receiver cannot stall
// reset (synchronous, active low) clears all valid bits and holds busy high
module pitot_airspeed_humid_density
    import pad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PRES_W-1:0] i_static_pressure,
    input  logic [PRES_W-1:0] i_total_pressure,
    input  logic [TEMP_W-1:0] i_temperature,
    input  logic [HUM_W-1:0]  i_humidity,
    output logic              o_done,
    output logic [OUT_W-1:0]  o_air_speed,
    output logic [OUT_W-1:0]  o_air_density,
    output logic [1:0]        o_status
);

    // sideband through the exponent divider
    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic [PRES_W-1:0] ps;
        logic [PRES_W-1:0] pt;
        logic              neg;
    } t_front;

    // carried through the polynomial and vapor pressure stages
    typedef struct packed {
        logic [15:0]       f;
        logic [5:0]        sh;
        logic [25:0]       hk;
        logic [TEMP_W-1:0] temp;
        logic [PRES_W-1:0] ps;
        logic [PRES_W-1:0] pt;
    } t_mid;

    // sideband through the 2^-32 density divider
    typedef struct packed {
        logic              npos;
        logic              lt;
        logic              gt;
        logic [PRES_W-1:0] dp;
        logic [47:0]       un;
        logic [DN_DW-1:0]  k;
    } t_rfsb;

    // sideband through the 1e-4 density divider
    typedef struct packed {
        logic              npos;
        logic              lt;
        logic              gt;
        logic [PRES_W-1:0] dp;
        logic [RF_QW-1:0]  rf;
    } t_dnsb;

    localparam int LAT = 12 + Y_QW + RF_QW + DN_QW + Q_QW + ROOT_W;
    localparam logic [YP_W-1:0] YP_OFS = YP_W'(1) << (YP_W - 1);

    logic accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ---------------------------------------------------------------
    // stage 1: exponent numerator magnitude and denominator
    // ---------------------------------------------------------------
    logic              n1_neg;
    logic [TEMP_W-1:0] n1_abs;
    logic [12:0]       n1_tb;
    logic              r1_v;
    logic [Y_NW-1:0]   r1_num;
    logic [Y_DW-1:0]   r1_den;
    t_front            r1_sb;

    always_comb begin
        n1_neg = i_temperature[TEMP_W-1];
        n1_abs = n1_neg ? (~i_temperature + 1'b1) : i_temperature;
        // t + 237.3 degC in tenths
        n1_tb  = 13'({{2{i_temperature[TEMP_W-1]}}, i_temperature} + 13'd2373);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= accept;
        end
        r1_num      <= Y_NW'(n1_abs) * Y_NW'(K_EXP);
        r1_den      <= Y_DW'(n1_tb) * Y_DW'(10);
        r1_sb.temp  <= i_temperature;
        r1_sb.hum   <= i_humidity;
        r1_sb.ps    <= i_static_pressure;
        r1_sb.pt    <= i_total_pressure;
        r1_sb.neg   <= n1_neg;
    end

    logic                       y_v;
    logic [Y_QW-1:0]            y_quo;
    logic [Y_DW-1:0]            y_rem;
    logic [$bits(t_front)-1:0]  y_sbv;
    t_front                     y_sb;

    pad_div #(
        .NUM_W (Y_NW),
        .DEN_W (Y_DW),
        .QUO_W (Y_QW),
        .SB_W  ($bits(t_front))
    ) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_num   (r1_num),
        .i_den   (r1_den),
        .i_sb    (r1_sb),
        .o_valid (y_v),
        .o_quo   (y_quo),
        .o_rem   (y_rem),
        .o_sb    (y_sbv)
    );

    assign y_sb = t_front'(y_sbv);

    // ---------------------------------------------------------------
    // stage 2: floored exponent, offset so integer part is positive
    // ---------------------------------------------------------------
    logic [Y_QW-1:0] n2_ymag;
    logic [YP_W-1:0] n2_yp;
    logic            r2_v;
    t_mid            r2_c;

    always_comb begin
        // negative quotient rounds toward minus infinity
        n2_ymag = y_quo + Y_QW'(y_rem != '0);
        n2_yp   = y_sb.neg ? (YP_OFS - n2_ymag) : (YP_OFS + y_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= y_v;
        end
        r2_c.f    <= n2_yp[15:0];
        // shift = 30 - e with e = (yp >> 16) - 32
        r2_c.sh   <= 6'd62 - n2_yp[YP_W-1:16];
        r2_c.hk   <= 26'(y_sb.hum) * 26'(TETENS_A);
        r2_c.temp <= y_sb.temp;
        r2_c.ps   <= y_sb.ps;
        r2_c.pt   <= y_sb.pt;
    end

    // ---------------------------------------------------------------
    // stages 3..6: horner steps for 2^(f/65536), then h*a*p
    // ---------------------------------------------------------------
    logic        r3_v, r4_v, r5_v, r6_v;
    t_mid        r3_c, r4_c, r5_c, r6_c;
    logic [42:0] r3_m;
    logic [44:0] r4_m;
    logic [45:0] r5_m;
    logic [56:0] r6_prod;
    logic [28:0] n4_p;
    logic [29:0] n5_p;
    logic [30:0] n6_p;

    always_comb begin
        n4_p = 29'(POLY_C2) + 29'(r3_m >> 16);
        n5_p = 30'(POLY_C1) + 30'(r4_m >> 16);
        n6_p = ONE_Q30 + 31'(r5_m >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
        r3_m    <= 43'(POLY_C3) * 43'(r2_c.f);
        r3_c    <= r2_c;
        r4_m    <= 45'(n4_p) * 45'(r3_c.f);
        r4_c    <= r3_c;
        r5_m    <= 46'(n5_p) * 46'(r4_c.f);
        r5_c    <= r4_c;
        r6_prod <= 57'(r5_c.hk) * 57'(n6_p);
        r6_c    <= r5_c;
    end

    // ---------------------------------------------------------------
    // stages 7..9: vapor pressure, numerator N, divisors
    // ---------------------------------------------------------------
    logic              r7_v, r8_v, r9_v;
    t_mid              r7_c, r8_c;
    logic [33:0]       r7_pv;
    logic [31:0]       r7_a, r8_a;
    logic [47:0]       r8_pvm;
    logic [11:0]       n9_d;
    logic [48:0]       r9_n;
    logic [DN_DW-1:0]  r9_k;
    logic [RF_DW-1:0]  r9_rfden;
    logic              r9_lt, r9_gt;
    logic [PRES_W-1:0] r9_dp;

    // t + 273 degC in tenths
    assign n9_d = 12'({r8_c.temp[TEMP_W-1], r8_c.temp} + 12'd2730);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
        r7_pv    <= 34'(r6_prod >> r6_c.sh);
        r7_a     <= 32'(r6_c.ps) * 32'(MD_MICRO);
        r7_c     <= r6_c;
        r8_pvm   <= 48'(r7_pv) * 48'(MDV_MICRO);
        r8_a     <= r7_a;
        r8_c     <= r7_c;
        // two's complement, bit 48 is the sign
        r9_n     <= {1'b0, r8_a, 16'd0} - {1'b0, r8_pvm};
        r9_k     <= DN_DW'(26'(n9_d) * 26'(R_MILLI));
        r9_rfden <= RF_DW'(n9_d) * RF_DW'(R_RF);
        r9_lt    <= (r8_c.pt < r8_c.ps);
        r9_gt    <= (r8_c.pt > r8_c.ps);
        r9_dp    <= r8_c.pt - r8_c.ps;
    end

    // ---------------------------------------------------------------
    // density in 2^-32 kg/m3: N*2^16 / (831400*d)
    // ---------------------------------------------------------------
    logic             n10_npos;
    logic [RF_NW-1:0] n10_num;
    t_rfsb            n10_sb;

    always_comb begin
        n10_npos    = ~r9_n[48] && (r9_n != '0);
        n10_num     = n10_npos ? {r9_n[47:0], 16'd0} : '0;
        n10_sb.npos = n10_npos;
        n10_sb.lt   = r9_lt;
        n10_sb.gt   = r9_gt;
        n10_sb.dp   = r9_dp;
        n10_sb.un   = r9_n[47:0];
        n10_sb.k    = r9_k;
    end

    logic                      rf_v;
    logic [RF_QW-1:0]          rf_quo;
    logic [$bits(t_rfsb)-1:0]  rf_sbv;
    t_rfsb                     rf_sb;

    pad_div #(
        .NUM_W (RF_NW),
        .DEN_W (RF_DW),
        .QUO_W (RF_QW),
        .SB_W  ($bits(t_rfsb))
    ) u_rfdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_v),
        .i_num   (n10_num),
        .i_den   (r9_rfden),
        .i_sb    (n10_sb),
        .o_valid (rf_v),
        .o_quo   (rf_quo),
        .o_rem   (),
        .o_sb    (rf_sbv)
    );

    assign rf_sb = t_rfsb'(rf_sbv);

    // ---------------------------------------------------------------
    // stage 11: rounded density numerator, (N*100 + 2^15*K) >> 16
    // ---------------------------------------------------------------
    logic [55:0]      n11_x;
    logic             r11_v;
    logic [DN_NW-1:0] r11_x;
    logic [DN_DW-1:0] r11_k;
    t_dnsb            r11_sb;

    assign n11_x = 56'(rf_sb.un) * 56'(100) + {16'd0, rf_sb.k, 15'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= rf_v;
        end
        r11_x       <= n11_x[54:16];
        r11_k       <= rf_sb.k;
        r11_sb.npos <= rf_sb.npos;
        r11_sb.lt   <= rf_sb.lt;
        r11_sb.gt   <= rf_sb.gt;
        r11_sb.dp   <= rf_sb.dp;
        r11_sb.rf   <= rf_quo;
    end

    logic                      dn_v;
    logic [DN_QW-1:0]          dn_quo;
    logic [$bits(t_dnsb)-1:0]  dn_sbv;
    t_dnsb                     dn_sb;

    pad_div #(
        .NUM_W (DN_NW),
        .DEN_W (DN_DW),
        .QUO_W (DN_QW),
        .SB_W  ($bits(t_dnsb))
    ) u_dndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_v),
        .i_num   (r11_x),
        .i_den   (r11_k),
        .i_sb    (r11_sb),
        .o_valid (dn_v),
        .o_quo   (dn_quo),
        .o_rem   (),
        .o_sb    (dn_sbv)
    );

    assign dn_sb = t_dnsb'(dn_sbv);

    // ---------------------------------------------------------------
    // stage 12: saturation check, q >= 2^32 iff dp*20000 >= rf
    // ---------------------------------------------------------------
    logic [31:0]     n12_p20;
    logic            r12_v;
    logic [31:0]     r12_hi;
    logic [Q_DW-1:0] r12_rf;
    t_fin            r12_fin;

    assign n12_p20 = 32'(dn_sb.dp) * 32'(DP_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else begin
            r12_v <= dn_v;
        end
        r12_hi       <= n12_p20;
        r12_rf       <= dn_sb.rf;
        r12_fin.dens <= dn_quo;
        r12_fin.npos <= dn_sb.npos;
        r12_fin.lt   <= dn_sb.lt;
        r12_fin.gt   <= dn_sb.gt;
        r12_fin.sat  <= dn_sb.gt &&
                        ((dn_sb.rf == '0) || ({2'b00, n12_p20} >= dn_sb.rf));
    end

    // squared speed: dp*20000*2^32 / rf, only when it fits, total exceeds static and density is positive
    logic [Q_NW-1:0] n13_num;

    assign n13_num = (r12_fin.sat || !r12_fin.gt || !r12_fin.npos) ?
                     '0 : {r12_hi, 32'd0};

    logic                     q_v;
    logic [Q_QW-1:0]          q_quo;
    logic [$bits(t_fin)-1:0]  q_sbv;

    pad_div #(
        .NUM_W (Q_NW),
        .DEN_W (Q_DW),
        .QUO_W (Q_QW),
        .SB_W  ($bits(t_fin))
    ) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r12_v),
        .i_num   (n13_num),
        .i_den   (r12_rf),
        .i_sb    (r12_fin),
        .o_valid (q_v),
        .o_quo   (q_quo),
        .o_rem   (),
        .o_sb    (q_sbv)
    );

    logic                     sq_v;
    logic [ROOT_W-1:0]        sq_root;
    logic [$bits(t_fin)-1:0]  sq_sbv;
    t_fin                     sq_fin;

    pad_sqrt #(
        .SB_W ($bits(t_fin))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_v),
        .i_rad   (q_quo),
        .i_sb    (q_sbv),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_sb    (sq_sbv)
    );

    assign sq_fin = t_fin'(sq_sbv);

    // ---------------------------------------------------------------
    // output register: status priority, nonpositive density first
    // ---------------------------------------------------------------
    logic             r_done;
    logic [OUT_W-1:0] r_speed;
    logic [OUT_W-1:0] r_dens;
    t_status          r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= sq_v;
        end
        priority if (!sq_fin.npos) begin
            r_speed  <= '0;
            r_dens   <= '0;
            r_status <= ST_NOPOS;
        end else if (sq_fin.lt) begin
            r_speed  <= '0;
            r_dens   <= sq_fin.dens;
            r_status <= ST_NEG;
        end else if (sq_fin.sat) begin
            r_speed  <= '1;
            r_dens   <= sq_fin.dens;
            r_status <= ST_SAT;
        end else if (sq_fin.gt) begin
            r_speed  <= sq_root;
            r_dens   <= sq_fin.dens;
            r_status <= ST_OK;
        end else begin
            r_speed  <= '0;
            r_dens   <= sq_fin.dens;
            r_status <= ST_OK;
        end
    end

    assign o_done        = r_done;
    assign o_air_speed   = r_speed;
    assign o_air_density = r_dens;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("word did not come out after the pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted word");

    a_nopos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NOPOS) |-> (o_air_speed == '0 && o_air_density == '0))
        else $error("nonpositive density must give zero outputs");

    a_neg_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NEG) |-> (o_air_speed == '0))
        else $error("total below static must give zero speed");

    a_sat_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_SAT) |-> (o_air_speed == '1))
        else $error("saturated status without full scale speed");
`endif

endmodule

// File: tb/sv/tb_pitot_airspeed_humid_density.sv
module tb_pitot_airspeed_humid_density;
    import pad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // pipeline depth of the block, matching LAT in the design; the final wait runs past it
    localparam int PIPE_LAT  = 132;
    localparam int N_RANDOM  = 1900;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        logic [OUT_W-1:0] speed;
        logic [OUT_W-1:0] dens;
        t_status          status;
    } t_airdata;

    // one row of the directed table
    typedef struct {
        logic [PRES_W-1:0] ps;
        logic [PRES_W-1:0] pt;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        bit                typed;   // expectation written into the row
        t_airdata          want;
    } t_vector;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [PRES_W-1:0] i_static_pressure;
    logic [PRES_W-1:0] i_total_pressure;
    logic [TEMP_W-1:0] i_temperature;
    logic [HUM_W-1:0]  i_humidity;
    logic              o_done;
    logic [OUT_W-1:0]  o_air_speed;
    logic [OUT_W-1:0]  o_air_density;
    logic [1:0]        o_status;

    t_airdata pending_air[$];
    int       n_errors;
    int       n_checked;
    int       n_sent;
    int       n_sat;
    int       n_neg;
    int       n_nopos;
    longint   n_cycles;

    pitot_airspeed_humid_density dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_static_pressure (i_static_pressure),
        .i_total_pressure  (i_total_pressure),
        .i_temperature     (i_temperature),
        .i_humidity        (i_humidity),
        .o_done            (o_done),
        .o_air_speed       (o_air_speed),
        .o_air_density     (o_air_density),
        .o_status          (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // integer square root, bit by bit
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // speed, density and status of one sample
    function automatic t_airdata calc_airdata(input logic [PRES_W-1:0] ps_i,
                                              input logic [PRES_W-1:0] pt_i,
                                              input logic [TEMP_W-1:0] t_i,
                                              input logic [HUM_W-1:0]  h_i);
        longint          t, ps, pt, num, den, y, e, sh, n;
        longint unsigned yp, fq, p, pv, hu, d, un, den_u, dens, dp, rf, q, spd;
        t_airdata        r;
        t  = longint'($signed(t_i));
        ps = longint'({47'd0, ps_i});
        pt = longint'({47'd0, pt_i});
        hu = {54'd0, h_i};
        // tetens exponent times log2(10) in q16, floored
        num = 75 * t * 217706;
        den = 10 * (t + 2373);
        if (num >= 0) y = num / den;
        else y = -((-num + den - 1) / den);
        yp = longint'(y + 32 * 65536);
        e  = longint'(yp >> 16) - 32;
        fq = (yp & 64'hFFFF) << 14;
        // 2^frac by horner, truncating every step
        p = 64'd85298265;
        p = 64'd241048919 + ((p * fq) >> 30);
        p = 64'd747394747 + ((p * fq) >> 30);
        p = 64'd1073741824 + ((p * fq) >> 30);
        sh = 30 - e;
        if (sh < 0) sh = 0;
        if (sh > 63) sh = 63;
        pv = (hu * 64'd40028 * p) >> sh;
        n = ps * 28964 * 65536 - longint'(pv) * 10948;
        d = longint'(t + 2730);
        r.speed  = '0;
        r.dens   = '0;
        r.status = ST_OK;
        if (n <= 0) begin
            r.status = ST_NOPOS;
        end else begin
            un    = n;
            den_u = 64'd65536 * 64'd8314 * d;
            dens  = (un * 100 + den_u / 2) / den_u;
            if (dens > 65535) dens = 65535;
            r.dens = dens[OUT_W-1:0];
            if (pt < ps) begin
                r.status = ST_NEG;
            end else if (pt > ps) begin
                dp = pt - ps;
                rf = (un * 64'd65536) / (64'd831400 * d);
                q  = 0;
                if (rf != 0) q = (dp * 64'd20000 * 64'd4294967296) / rf;
                if (rf == 0 || q >= 64'd4294967296) begin
                    r.speed  = 16'hFFFF;
                    r.status = ST_SAT;
                end else begin
                    spd = root64(q);
                    if (spd > 65535) spd = 65535;
                    r.speed = spd[OUT_W-1:0];
                end
            end
        end
        return r;
    endfunction

    // hand one word to the block; the expectation is queued at the accepting edge
    task automatic send_sample(input logic [PRES_W-1:0] ps, input logic [PRES_W-1:0] pt,
                               input logic [TEMP_W-1:0] temp, input logic [HUM_W-1:0] hum,
                               input bit typed, input t_airdata want);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_static_pressure <= ps;
        i_total_pressure  <= pt;
        i_temperature     <= temp;
        i_humidity        <= hum;
        // busy only moves at a rising edge, so the value at the falling edge is
        // what the block sees at the next rising one
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        pending_air.push_back(typed ? want : calc_airdata(ps, pt, temp, hum));
        n_sent++;
    endtask

    task automatic wait_drained;
        start <= 1'b0;
        while (pending_air.size() != 0) @(posedge i_clk);
    endtask

    // result checker: o_done is a one-cycle strobe, nothing can hold it off
    always @(posedge i_clk) begin
        t_airdata w;
        if (i_rst_n && o_done) begin
            if (pending_air.size() == 0) begin
                $error("result word with nothing expected: speed %0d density %0d status %0d",
                       o_air_speed, o_air_density, o_status);
                n_errors++;
            end else begin
                w = pending_air.pop_front();
                n_checked++;
                if (o_air_speed !== w.speed) begin
                    $error("air_speed: expected %0d, got %0d", w.speed, o_air_speed);
                    n_errors++;
                end
                if (o_air_density !== w.dens) begin
                    $error("air_density: expected %0d, got %0d", w.dens, o_air_density);
                    n_errors++;
                end
                if (o_status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, o_status);
                    n_errors++;
                end
                case (w.status)
                    ST_SAT:   n_sat++;
                    ST_NEG:   n_neg++;
                    ST_NOPOS: n_nopos++;
                    default: ;
                endcase
            end
        end
    end

    // watchdog
    initial begin
        n_cycles = 0;
        forever begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles > CYC_LIMIT) begin
                $display("timeout after %0d cycles, %0d words still expected",
                         n_cycles, pending_air.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_vector  vecs[$];
        t_vector  v;
        t_airdata none;
        int       kind;
        logic [PRES_W-1:0] ps, pt;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;

        n_errors  = 0;
        n_checked = 0;
        n_sent    = 0;
        n_sat     = 0;
        n_neg     = 0;
        n_nopos   = 0;
        none      = '{speed: '0, dens: '0, status: ST_OK};

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_static_pressure = '0;
        i_total_pressure  = '0;
        i_temperature     = '0;
        i_humidity        = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero pressure and dry air: numerator is exactly zero, density not positive
        vecs.push_back('{17'd0, 17'd0, 11'd0, 10'd0, 1'b1, '{16'd0, 16'd0, ST_NOPOS}});
        // zero static with humid air: vapour pushes the numerator below zero
        vecs.push_back('{17'd0, 17'h1FFFF, 11'd850, 10'd1000, 1'b1,
                         '{16'd0, 16'd0, ST_NOPOS}});
        // very humid hot air at low pressure
        vecs.push_back('{17'd100, 17'd5000, 11'd1023, 10'd1023, 1'b0, none});
        // sea level, still air
        vecs.push_back('{17'd101325, 17'd101325, 11'd200, 10'd500, 1'b0, none});
        // total below static
        vecs.push_back('{17'd101325, 17'd100000, 11'd200, 10'd500, 1'b0, none});
        vecs.push_back('{17'h1FFFF, 17'd0, 11'd0, 10'd0, 1'b0, none});
        // small and moderate differences
        vecs.push_back('{17'd101325, 17'd101326, 11'd150, 10'd300, 1'b0, none});
        vecs.push_back('{17'd101325, 17'd102000, 11'd250, 10'd600, 1'b0, none});
        vecs.push_back('{17'd90000, 17'd95000, 11'h670, 10'd0, 1'b0, none});
        // thin air, large difference: hot humid air gives a density that is not positive, dry air saturates the speed
        vecs.push_back('{17'd1000, 17'h1FFFF, 11'd850, 10'd1000, 1'b0, none});
        vecs.push_back('{17'd1, 17'h1FFFF, 11'd0, 10'd0, 1'b0, none});
        // full-scale pressures
        vecs.push_back('{17'h1FFFF, 17'h1FFFF, 11'd0, 10'd0, 1'b0, none});
        vecs.push_back('{17'h1FFFE, 17'h1FFFF, 11'h400, 10'd0, 1'b0, none});
        // temperature extremes, in and out of the rated range, and a tenth of a degree below zero
        vecs.push_back('{17'd101325, 17'd103000, 11'h670, 10'd1000, 1'b0, none});
        vecs.push_back('{17'd101325, 17'd103000, 11'h400, 10'd1023, 1'b0, none});
        vecs.push_back('{17'd101325, 17'd103000, 11'd1023, 10'd1000, 1'b0, none});
        vecs.push_back('{17'd101325, 17'd103000, 11'h7FF, 10'd1, 1'b0, none});
        // humidity out of range, hot: vapour term dominates at the lower static pressure
        vecs.push_back('{17'd20000, 17'd21000, 11'd1023, 10'd1023, 1'b0, none});
        vecs.push_back('{17'd50000, 17'd50000, 11'd600, 10'd1023, 1'b0, none});

        foreach (vecs[i]) begin
            v = vecs[i];
            send_sample(v.ps, v.pt, v.temp, v.hum, v.typed, v.want);
        end
        // hold the sender off until the pipe is empty
        wait_drained();

        for (int k = 0; k < N_RANDOM; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // realistic flight envelope
                ps   = PRES_W'($urandom_range(30000, 110000));
                pt   = PRES_W'(ps + $urandom_range(0, 8000));
                temp = 11'($signed($urandom_range(0, 1250)) - 400);
                hum  = HUM_W'($urandom_range(0, 1000));
            end else if (kind < 8) begin
                // near equal pressures, either sign of difference
                ps   = PRES_W'($urandom_range(1000, 130000));
                pt   = PRES_W'(ps + $urandom_range(0, 20) - 10);
                temp = 11'($signed($urandom_range(0, 1250)) - 400);
                hum  = HUM_W'($urandom_range(0, 1000));
            end else begin
                // random bit patterns over the full width of every field
                ps   = PRES_W'($urandom());
                pt   = PRES_W'($urandom());
                temp = TEMP_W'($urandom());
                hum  = HUM_W'($urandom());
            end
            send_sample(ps, pt, temp, hum, 1'b0, none);
            // now and then let the pipe run dry mid-stream
            if ($urandom_range(0, 299) == 0) wait_drained();
        end

        wait_drained();
        repeat (PIPE_LAT + 20) @(posedge i_clk);

        $display("sent %0d samples, checked %0d results", n_sent, n_checked);
        $display("saturated %0d, total below static %0d, density not positive %0d",
                 n_sat, n_neg, n_nopos);
        if (n_errors == 0 && pending_air.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending_air.size() != 0) begin
                $error("%0d expected results never arrived", pending_air.size());
            end
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
